### hw/rtl/dmsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmsp_pkg: shared types and constants
// Widths, register map, reset values and the current classifier used by the
// dual motor speed controller.
// ----------------------------------------------------------------------------
package dmsp_pkg;

  localparam int SPEED_W    = 16;
  localparam int CURRENT_W  = 16;
  localparam int DRIVE_W    = 16;
  localparam int GAIN_W     = 20;
  localparam int LIMIT_W    = 15;
  localparam int STATUS_W   = 2;
  localparam int CNT_W      = 10;
  localparam int FRAC_W     = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 40;

  // Widths inside the PID datapath.
  localparam int ERR_W  = SPEED_W + 1;
  localparam int DERR_W = SPEED_W + 2;
  localparam int PROD_W = 38;
  localparam int ACC_W  = 32;
  localparam int PPD_W  = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  localparam int DEF_STARTUP_TICKS = 50;

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_SPEED_0 = 3'd0,
    REG_TARGET_SPEED_1 = 3'd1,
    REG_GAIN_P         = 3'd2,
    REG_GAIN_I         = 3'd3,
    REG_GAIN_D         = 3'd4,
    REG_INTEGRAL_LIMIT = 3'd5,
    REG_OUTPUT_LIMIT   = 3'd6
  } reg_idx_t;

  localparam logic [GAIN_W-1:0]  RST_GAIN_P         = 20'd131072;
  localparam logic [GAIN_W-1:0]  RST_GAIN_I         = 20'd6554;
  localparam logic [GAIN_W-1:0]  RST_GAIN_D         = 20'd13107;
  localparam logic [LIMIT_W-1:0] RST_INTEGRAL_LIMIT = 15'd3000;
  localparam logic [LIMIT_W-1:0] RST_OUTPUT_LIMIT   = 15'd10000;

  // Current class thresholds in milliamps.
  localparam logic [CURRENT_W-2:0] LIM_LOADED      = 15'd3000;
  localparam logic [CURRENT_W-2:0] LIM_OBSTACLE    = 15'd8000;
  localparam logic [CURRENT_W-2:0] LIM_OVERCURRENT = 15'd12000;

  typedef enum logic [STATUS_W-1:0] {
    ST_NORMAL      = 2'd0,
    ST_LOADED      = 2'd1,
    ST_OBSTACLE    = 2'd2,
    ST_OVERCURRENT = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] target_speed_0;
    logic signed [SPEED_W-1:0] target_speed_1;
    logic [GAIN_W-1:0]         gain_p;
    logic [GAIN_W-1:0]         gain_i;
    logic [GAIN_W-1:0]         gain_d;
    logic [LIMIT_W-1:0]        integral_limit;
    logic [LIMIT_W-1:0]        output_limit;
  } cfg_t;

  // Pipeline control handed to each PID lane.
  typedef struct packed {
    logic advance;  // whole pipeline moves at this edge
    logic s0_run;   // input stage holds a regulated (non startup) item
    logic s1_run;   // product stage holds a regulated item
  } pid_ctrl_t;

  // Sort the absolute current into a class; the magnitude of the most
  // negative code saturates to the largest positive one.
  function automatic status_t classify(input logic signed [CURRENT_W-1:0] cur);
    logic [CURRENT_W-1:0] neg;
    logic [CURRENT_W-2:0] mag;
    begin
      neg = CURRENT_W'(-cur);
      if (cur == {1'b1, {(CURRENT_W-1){1'b0}}}) begin
        mag = {(CURRENT_W-1){1'b1}};
      end else if (cur[CURRENT_W-1]) begin
        mag = neg[CURRENT_W-2:0];
      end else begin
        mag = cur[CURRENT_W-2:0];
      end
      if (mag > LIM_OVERCURRENT) begin
        classify = ST_OVERCURRENT;
      end else if (mag > LIM_OBSTACLE) begin
        classify = ST_OBSTACLE;
      end else if (mag > LIM_LOADED) begin
        classify = ST_LOADED;
      end else begin
        classify = ST_NORMAL;
      end
    end
  endfunction

endpackage
`default_nettype wire

### hw/rtl/dmsp_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmsp_cfg_regs: configuration register file
// Holds target speeds, PID gains and clamp limits; written by index.
// ----------------------------------------------------------------------------
module dmsp_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [dmsp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dmsp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output dmsp_pkg::cfg_t                          cfg
);
  import dmsp_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_speed_0 <= '0;
      cfg_r.target_speed_1 <= '0;
      cfg_r.gain_p         <= RST_GAIN_P;
      cfg_r.gain_i         <= RST_GAIN_I;
      cfg_r.gain_d         <= RST_GAIN_D;
      cfg_r.integral_limit <= RST_INTEGRAL_LIMIT;
      cfg_r.output_limit   <= RST_OUTPUT_LIMIT;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TARGET_SPEED_0: cfg_r.target_speed_0 <= cfg_wdata[SPEED_W-1:0];
        REG_TARGET_SPEED_1: cfg_r.target_speed_1 <= cfg_wdata[SPEED_W-1:0];
        REG_GAIN_P:         cfg_r.gain_p         <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:         cfg_r.gain_i         <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:         cfg_r.gain_d         <= cfg_wdata[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: cfg_r.integral_limit <= cfg_wdata[LIMIT_W-1:0];
        REG_OUTPUT_LIMIT:   cfg_r.output_limit   <= cfg_wdata[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

### hw/rtl/dmsp_pid.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmsp_pid: one PID lane
// Products in the first stage, integral update and P+D sum in the second,
// final add, output clamp and truncation toward zero after that.
// ----------------------------------------------------------------------------
module dmsp_pid (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  dmsp_pkg::pid_ctrl_t                          ctrl,
  input  wire logic signed [dmsp_pkg::SPEED_W-1:0]     target,
  input  wire logic signed [dmsp_pkg::SPEED_W-1:0]     speed_meas,
  input  wire logic [dmsp_pkg::GAIN_W-1:0]             gain_p,
  input  wire logic [dmsp_pkg::GAIN_W-1:0]             gain_i,
  input  wire logic [dmsp_pkg::GAIN_W-1:0]             gain_d,
  input  wire logic [dmsp_pkg::LIMIT_W-1:0]            integral_limit,
  input  wire logic [dmsp_pkg::LIMIT_W-1:0]            output_limit,
  output logic signed [dmsp_pkg::DRIVE_W-1:0]          drive
);
  import dmsp_pkg::*;

  // Error terms from the registered input.
  logic signed [ERR_W-1:0]  err;
  logic signed [DERR_W-1:0] derr;
  logic signed [ERR_W-1:0]  prev_err_r;

  // Product stage.
  logic signed [PROD_W-1:0] pp_nxt, pi_nxt, pd_nxt;
  logic signed [PROD_W-1:0] pp_r, pi_r, pd_r;

  // Integral stage.
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [PPD_W-1:0]  acc_sum;
  logic signed [PPD_W-1:0]  ilim;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [PPD_W-1:0]  ppd_nxt;
  logic signed [PPD_W-1:0]  ppd_r;
  logic signed [ACC_W-1:0]  s2_acc_r;

  // Output stage.
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  olim;
  logic signed [SUM_W-1:0]  sum_cl;
  logic signed [SUM_W-1:0]  sum_adj;

  assign err  = $signed({target[SPEED_W-1], target})
              - $signed({speed_meas[SPEED_W-1], speed_meas});
  assign derr = $signed({err[ERR_W-1], err}) - $signed({prev_err_r[ERR_W-1], prev_err_r});

  assign pp_nxt = err  * $signed({1'b0, gain_p});
  assign pi_nxt = err  * $signed({1'b0, gain_i});
  assign pd_nxt = derr * $signed({1'b0, gain_d});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
    end else if (ctrl.advance && ctrl.s0_run) begin
      prev_err_r <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      pp_r <= pp_nxt;
      pi_r <= pi_nxt;
      pd_r <= pd_nxt;
    end
  end

  // The integral limit is in milliamps; the accumulator keeps 16 fraction bits.
  assign ilim    = $signed({{(PPD_W-LIMIT_W-FRAC_W){1'b0}}, integral_limit, {FRAC_W{1'b0}}});
  assign acc_sum = $signed({{(PPD_W-ACC_W){acc_r[ACC_W-1]}}, acc_r})
                 + $signed({pi_r[PROD_W-1], pi_r});

  always_comb begin
    if (acc_sum > ilim) begin
      acc_nxt = ilim[ACC_W-1:0];
    end else if (acc_sum < -ilim) begin
      acc_nxt = ACC_W'(-ilim);
    end else begin
      acc_nxt = acc_sum[ACC_W-1:0];
    end
  end

  assign ppd_nxt = $signed({pp_r[PROD_W-1], pp_r}) + $signed({pd_r[PROD_W-1], pd_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctrl.advance && ctrl.s1_run) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      ppd_r    <= ppd_nxt;
      s2_acc_r <= acc_nxt;
    end
  end

  assign sum  = $signed({ppd_r[PPD_W-1], ppd_r})
              + $signed({{(SUM_W-ACC_W){s2_acc_r[ACC_W-1]}}, s2_acc_r});
  assign olim = $signed({{(SUM_W-LIMIT_W-FRAC_W){1'b0}}, output_limit, {FRAC_W{1'b0}}});

  always_comb begin
    if (sum > olim) begin
      sum_cl = olim;
    end else if (sum < -olim) begin
      sum_cl = -olim;
    end else begin
      sum_cl = sum;
    end
  end

  // Truncation toward zero: bias negative values before dropping the fraction.
  assign sum_adj = sum_cl[SUM_W-1]
                 ? sum_cl + $signed({{(SUM_W-FRAC_W){1'b0}}, {FRAC_W{1'b1}}})
                 : sum_cl;
  assign drive   = sum_adj[FRAC_W+DRIVE_W-1:FRAC_W];

endmodule
`default_nettype wire

### hw/rtl/dual_motor_speed_pid_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dual_motor_speed_pid_top: two-motor speed PID with integral clamp
// Streaming wrapper, soft start counter, current classifier and two PID lanes.
// ----------------------------------------------------------------------------
// One input transaction carries the measured speed and current of both motors
// for one control tick, and produces exactly one output transaction with the
// two clamped drive currents, the two current classes and the startup flag.
// The first STARTUP_TICKS ticks after reset return zero drive and normal status
// with the startup flag set and leave the PID state untouched. The block takes
// a new transaction every cycle unless the pipeline holds; a result passes
// from the input register, loaded at the edge that accepts its input, through
// the product, integral and output registers. The whole pipeline holds while
// the output register is full and not taken, so in_tready follows out_tready
// in that case. The user must write configuration registers through the cfg
// port only while no tick is in flight; the block itself does not enforce it.
module dual_motor_speed_pid_top #(
  parameter int STARTUP_TICKS = dmsp_pkg::DEF_STARTUP_TICKS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // tdata: speed_meas_0, current_meas_0, speed_meas_1, current_meas_1
  input  wire logic [dmsp_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // tdata: drive_current_0, drive_current_1, status_0, status_1, zero pad
  output logic [dmsp_pkg::OUT_DATA_W-1:0]          out_tdata,
  // tuser: in_startup
  output logic                                     out_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  input  wire logic                                cfg_wr_en,
  input  wire logic [dmsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [dmsp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import dmsp_pkg::*;

  localparam logic [CNT_W-1:0] STARTUP_LIM = CNT_W'(STARTUP_TICKS);

  cfg_t      cfg;
  pid_ctrl_t ctrl;
  logic      advance;
  logic      in_fire;
  logic      startup_now;

  logic [CNT_W-1:0] startup_cnt_r;

  // Input stage.
  logic                        s0_valid_r, s0_startup_r;
  logic signed [SPEED_W-1:0]   s0_speed0_r, s0_speed1_r;
  logic signed [CURRENT_W-1:0] s0_cur0_r, s0_cur1_r;
  status_t                     s0_status0, s0_status1;

  // Later stages carry control and status alongside the PID lanes.
  logic    s1_valid_r, s1_startup_r, s2_valid_r, s2_startup_r;
  status_t s1_status0_r, s1_status1_r, s2_status0_r, s2_status1_r;

  logic signed [DRIVE_W-1:0] drive0, drive1;

  logic                      out_valid_r;
  logic                      out_startup_r;
  logic signed [DRIVE_W-1:0] out_drive0_r, out_drive1_r;
  status_t                   out_status0_r, out_status1_r;

  assign advance     = !out_valid_r || out_tready;
  assign in_tready   = advance;
  assign in_fire     = in_tvalid && advance;
  assign startup_now = startup_cnt_r < STARTUP_LIM;

  assign ctrl.advance = advance;
  assign ctrl.s0_run  = s0_valid_r && !s0_startup_r;
  assign ctrl.s1_run  = s1_valid_r && !s1_startup_r;

  dmsp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      startup_cnt_r <= '0;
    end else if (in_fire && startup_now) begin
      startup_cnt_r <= startup_cnt_r + 1'b1;
    end
  end

  // Control flags of the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s0_valid_r  <= in_tvalid;
      s1_valid_r  <= s0_valid_r;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_startup_r <= startup_now;
      s0_speed0_r  <= in_tdata[15:0];
      s0_cur0_r    <= in_tdata[31:16];
      s0_speed1_r  <= in_tdata[47:32];
      s0_cur1_r    <= in_tdata[63:48];
      s1_startup_r <= s0_startup_r;
      s1_status0_r <= s0_status0;
      s1_status1_r <= s0_status1;
      s2_startup_r <= s1_startup_r;
      s2_status0_r <= s1_status0_r;
      s2_status1_r <= s1_status1_r;
    end
  end

  assign s0_status0 = classify(s0_cur0_r);
  assign s0_status1 = classify(s0_cur1_r);

  dmsp_pid u_pid0 (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .target         (cfg.target_speed_0),
    .speed_meas     (s0_speed0_r),
    .gain_p         (cfg.gain_p),
    .gain_i         (cfg.gain_i),
    .gain_d         (cfg.gain_d),
    .integral_limit (cfg.integral_limit),
    .output_limit   (cfg.output_limit),
    .drive          (drive0)
  );

  dmsp_pid u_pid1 (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .target         (cfg.target_speed_1),
    .speed_meas     (s0_speed1_r),
    .gain_p         (cfg.gain_p),
    .gain_i         (cfg.gain_i),
    .gain_d         (cfg.gain_d),
    .integral_limit (cfg.integral_limit),
    .output_limit   (cfg.output_limit),
    .drive          (drive1)
  );

  // Soft start ticks report zero drive and normal status.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_startup_r <= s2_startup_r;
      out_drive0_r  <= s2_startup_r ? '0 : drive0;
      out_drive1_r  <= s2_startup_r ? '0 : drive1;
      out_status0_r <= s2_startup_r ? ST_NORMAL : s2_status0_r;
      out_status1_r <= s2_startup_r ? ST_NORMAL : s2_status1_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_startup_r;
  assign out_tdata  = {{(OUT_DATA_W-2*DRIVE_W-2*STATUS_W){1'b0}},
                       out_status1_r, out_status0_r, out_drive1_r, out_drive0_r};

endmodule
`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the dual motor speed PID
// Streams control ticks with random gaps on both sides. Each accepted tick is
// run through a local model of the soft start, the two PID lanes and the
// current classifier, and the result stream is compared field by field.
// ----------------------------------------------------------------------------
module tb;
  import dmsp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 10;
  localparam int TICKS_PER_PHASE = 200;

  typedef struct {
    logic signed [SPEED_W-1:0]   speed_0;
    logic signed [CURRENT_W-1:0] current_0;
    logic signed [SPEED_W-1:0]   speed_1;
    logic signed [CURRENT_W-1:0] current_1;
  } tick_t;

  typedef struct {
    logic signed [DRIVE_W-1:0] drive_0;
    logic signed [DRIVE_W-1:0] drive_1;
    status_t                   status_0;
    status_t                   status_1;
    logic                      startup;
  } drive_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Controller model state.
  cfg_t                      ctl_cfg;
  logic [CNT_W-1:0]          soft_start_ticks;
  logic signed [33:0]        integ_acc [2];
  logic signed [ERR_W-1:0]   last_err [2];

  tick_t  pending_ticks [$];
  drive_t expected_drive [$];
  tick_t  bus_tick;
  logic   hold_steady = 1'b0;
  int     mismatches = 0;
  int     ticks_sent = 0;
  int     results_seen = 0;
  int     settings_used = 0;

  dual_motor_speed_pid_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic status_t current_class(input logic signed [CURRENT_W-1:0] cur);
    int mag;
    begin
      mag = (cur < 0) ? -int'(cur) : int'(cur);
      if (mag > 32767) mag = 32767;
      if (mag > 12000) return ST_OVERCURRENT;
      if (mag > 8000) return ST_OBSTACLE;
      if (mag > 3000) return ST_LOADED;
      return ST_NORMAL;
    end
  endfunction

  // One PID lane; all sums carry 16 fractional bits until the final division.
  function automatic logic signed [DRIVE_W-1:0] pid_lane(input int m,
      input logic signed [SPEED_W-1:0] target, input logic signed [SPEED_W-1:0] meas);
    longint err, ilim, olim, acc, sum;
    begin
      err  = longint'(target) - longint'(meas);
      ilim = longint'(ctl_cfg.integral_limit) * 65536;
      olim = longint'(ctl_cfg.output_limit) * 65536;
      acc  = longint'(integ_acc[m]) + err * longint'(ctl_cfg.gain_i);
      if (acc > ilim) acc = ilim;
      if (acc < -ilim) acc = -ilim;
      integ_acc[m] = acc[33:0];
      sum = err * longint'(ctl_cfg.gain_p) + acc
          + (err - longint'(last_err[m])) * longint'(ctl_cfg.gain_d);
      last_err[m] = err[ERR_W-1:0];
      if (sum > olim) sum = olim;
      if (sum < -olim) sum = -olim;
      sum = sum / 65536;
      return sum[DRIVE_W-1:0];
    end
  endfunction

  function automatic drive_t predict_drive(input tick_t t);
    drive_t r;
    begin
      if (soft_start_ticks < DEF_STARTUP_TICKS) begin
        soft_start_ticks = soft_start_ticks + 1'b1;
        r.drive_0  = '0;
        r.drive_1  = '0;
        r.status_0 = ST_NORMAL;
        r.status_1 = ST_NORMAL;
        r.startup  = 1'b1;
      end else begin
        r.drive_0  = pid_lane(0, ctl_cfg.target_speed_0, t.speed_0);
        r.drive_1  = pid_lane(1, ctl_cfg.target_speed_1, t.speed_1);
        r.status_0 = current_class(t.current_0);
        r.status_1 = current_class(t.current_1);
        r.startup  = 1'b0;
      end
      return r;
    end
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_TARGET_SPEED_0: ctl_cfg.target_speed_0 = data[SPEED_W-1:0];
      REG_TARGET_SPEED_1: ctl_cfg.target_speed_1 = data[SPEED_W-1:0];
      REG_GAIN_P:         ctl_cfg.gain_p = data[GAIN_W-1:0];
      REG_GAIN_I:         ctl_cfg.gain_i = data[GAIN_W-1:0];
      REG_GAIN_D:         ctl_cfg.gain_d = data[GAIN_W-1:0];
      REG_INTEGRAL_LIMIT: ctl_cfg.integral_limit = data[LIMIT_W-1:0];
      REG_OUTPUT_LIMIT:   ctl_cfg.output_limit = data[LIMIT_W-1:0];
      default: ;
    endcase
  endfunction

  // The write enable is left high between back-to-back writes; close_writes
  // lowers it after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    apply_reg(idx, data);
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // Polls on the falling edge so that the clocked processes have settled.
  task automatic wait_drained();
    while (pending_ticks.size() > 0 || in_tvalid || expected_drive.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic tick_t make_tick(input int s0, input int c0, input int s1, input int c1);
    tick_t t;
    begin
      t.speed_0   = s0[SPEED_W-1:0];
      t.current_0 = c0[CURRENT_W-1:0];
      t.speed_1   = s1[SPEED_W-1:0];
      t.current_1 = c1[CURRENT_W-1:0];
      return t;
    end
  endfunction

  function automatic int clamp_speed(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int rand_current();
    int thr [3];
    int c;
    begin
      thr = '{3000, 8000, 12000};
      if ($urandom_range(1) == 1) begin
        c = thr[$urandom_range(2)] + int'($urandom_range(6)) - 3;
        if ($urandom_range(1) == 1) c = -c;
      end else begin
        c = int'($signed(16'($urandom())));
      end
      return c;
    end
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      2: return CFG_DATA_W'($urandom());
      3: return CFG_DATA_W'($urandom_range(262143));
      default: return CFG_DATA_W'($urandom_range(20000));
    endcase
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return LIMIT_W'($urandom());
      default: return LIMIT_W'($urandom_range(12000));
    endcase
  endfunction

  // Random register set; bits above each register's width carry junk.
  task automatic random_settings();
    logic [CFG_DATA_W-1:0] w;
    w = CFG_DATA_W'($urandom());
    if ($urandom_range(3) == 0) w[SPEED_W-1:0] = $urandom_range(1) ? 16'h7FFF : 16'h8000;
    write_reg(REG_TARGET_SPEED_0, w);
    w = CFG_DATA_W'($urandom());
    if ($urandom_range(1) == 0) w[SPEED_W-1:0] = SPEED_W'(int'($urandom_range(4000)) - 2000);
    write_reg(REG_TARGET_SPEED_1, w);
    write_reg(REG_GAIN_P, pick_gain());
    write_reg(REG_GAIN_I, pick_gain());
    write_reg(REG_GAIN_D, pick_gain());
    w = CFG_DATA_W'($urandom());
    w[LIMIT_W-1:0] = pick_limit();
    write_reg(REG_INTEGRAL_LIMIT, w);
    w = CFG_DATA_W'($urandom());
    w[LIMIT_W-1:0] = pick_limit();
    write_reg(REG_OUTPUT_LIMIT, w);
    if ($urandom_range(1) == 1) write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
    close_writes();
  endtask

  // Mostly speeds that track the targets so the integral winds up and back;
  // the rest is noise across the whole range.
  task automatic queue_random_ticks(input int count);
    int span, s0, s1;
    @(negedge clk);
    span = ($urandom_range(2) == 0) ? 20 : ($urandom_range(1) ? 500 : 5000);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(9) < 7) begin
        s0 = clamp_speed(int'(ctl_cfg.target_speed_0)
                         + int'($urandom_range(2 * span)) - span);
        s1 = clamp_speed(int'(ctl_cfg.target_speed_1)
                         + int'($urandom_range(2 * span)) - span);
      end else begin
        s0 = int'($signed(16'($urandom())));
        s1 = int'($signed(16'($urandom())));
      end
      pending_ticks.push_back(make_tick(s0, rand_current(), s1, rand_current()));
    end
  endtask

  // Driver: a tick stays on the bus until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_drive.push_back(predict_drive(bus_tick));
        ticks_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_ticks.size() > 0 && (hold_steady || $urandom_range(99) >= 9)) begin
          bus_tick = pending_ticks.pop_front();
          in_tdata <= {bus_tick.current_1, bus_tick.speed_1,
                       bus_tick.current_0, bus_tick.speed_0};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      mismatches++;
    end
  endtask

  // Monitor: compares each result transaction with the oldest prediction.
  always @(posedge clk) begin
    drive_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_drive.size() == 0) begin
          $error("unexpected result transaction: tdata %h", out_tdata);
          mismatches++;
        end else begin
          want = expected_drive.pop_front();
          check_field("drive_current_0", int'(want.drive_0), int'($signed(out_tdata[15:0])));
          check_field("drive_current_1", int'(want.drive_1), int'($signed(out_tdata[31:16])));
          check_field("status_0", int'(want.status_0), int'(out_tdata[33:32]));
          check_field("status_1", int'(want.status_1), int'(out_tdata[35:34]));
          check_field("in_startup", int'(want.startup), int'(out_tuser));
        end
      end
      out_tready <= hold_steady || ($urandom_range(99) >= 9);
    end
  end

  initial begin
    ctl_cfg.target_speed_0 = '0;
    ctl_cfg.target_speed_1 = '0;
    ctl_cfg.gain_p         = RST_GAIN_P;
    ctl_cfg.gain_i         = RST_GAIN_I;
    ctl_cfg.gain_d         = RST_GAIN_D;
    ctl_cfg.integral_limit = RST_INTEGRAL_LIMIT;
    ctl_cfg.output_limit   = RST_OUTPUT_LIMIT;
    soft_start_ticks = '0;
    integ_acc = '{default: '0};
    last_err  = '{default: '0};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    settings_used = 1;

    // Soft start: the fields are ignored, so random ticks plus a few extremes.
    @(negedge clk);
    pending_ticks.push_back(make_tick(-32768, -32768, 32767, 32767));
    pending_ticks.push_back(make_tick(32767, 32767, -32768, -32768));
    queue_random_ticks(DEF_STARTUP_TICKS - 2);
    wait_drained();

    // Reset settings: class thresholds, most negative current, speed extremes
    // that drive the integral into its clamp, and a steady error that winds it up.
    @(negedge clk);
    pending_ticks.push_back(make_tick(0, 0, 0, 0));
    pending_ticks.push_back(make_tick(32767, 3000, -32768, 3001));
    pending_ticks.push_back(make_tick(-32768, 8000, 32767, 8001));
    pending_ticks.push_back(make_tick(0, 12000, 0, 12001));
    pending_ticks.push_back(make_tick(1, -32768, -1, 32767));
    pending_ticks.push_back(make_tick(0, -3001, 0, -12001));
    pending_ticks.push_back(make_tick(0, -8001, 0, -1));
    for (int k = 0; k < 4; k++) pending_ticks.push_back(make_tick(-1000, 100, 1000, -100));
    wait_drained();

    // Gains and limits at their top values, targets at the speed extremes, with the largest possible errors.
    write_reg(REG_TARGET_SPEED_0, 20'hF7FFF);
    write_reg(REG_TARGET_SPEED_1, 20'h08000);
    write_reg(REG_GAIN_P, '1);
    write_reg(REG_GAIN_I, '1);
    write_reg(REG_GAIN_D, '1);
    write_reg(REG_INTEGRAL_LIMIT, '1);
    write_reg(REG_OUTPUT_LIMIT, '1);
    close_writes();
    @(negedge clk);
    pending_ticks.push_back(make_tick(-32768, 0, 32767, 0));
    pending_ticks.push_back(make_tick(32767, 0, -32768, 0));
    pending_ticks.push_back(make_tick(-32768, 0, 32767, 0));
    wait_drained();

    // Zero gains and limits; the unused index must not disturb anything.
    write_reg(REG_GAIN_P, '0);
    write_reg(REG_GAIN_I, '0);
    write_reg(REG_GAIN_D, '0);
    write_reg(REG_INTEGRAL_LIMIT, 20'hF8000);
    write_reg(REG_OUTPUT_LIMIT, 20'h78000);
    write_reg(REG_UNUSED, '1);
    close_writes();
    @(negedge clk);
    pending_ticks.push_back(make_tick(0, 0, 0, 0));
    pending_ticks.push_back(make_tick(-32768, 0, 32767, 0));
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      random_settings();
      hold_steady = (ph == RANDOM_PHASES / 2);
      queue_random_ticks(TICKS_PER_PHASE);
      wait_drained();
      hold_steady = 1'b0;
    end

    $display("Checked %0d results from %0d control ticks across %0d register settings.",
             results_seen, ticks_sent, settings_used);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results still expected.", expected_drive.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
